### hw/rtl/rna_pkg.sv
// Shared constants and operation codes for the rational number ALU.
package rna_pkg;

	localparam int OperandWidthDefault = 16;
	localparam int OpWidth = 4;
	localparam int ResNumWidth = 32;
	localparam int ResDenWidth = 31;

	localparam logic [OpWidth-1:0] OP_ADD = 4'd0;
	localparam logic [OpWidth-1:0] OP_SUB = 4'd1;
	localparam logic [OpWidth-1:0] OP_MUL = 4'd2;
	localparam logic [OpWidth-1:0] OP_DIV = 4'd3;
	localparam logic [OpWidth-1:0] OP_LT  = 4'd4;
	localparam logic [OpWidth-1:0] OP_GT  = 4'd5;
	localparam logic [OpWidth-1:0] OP_LE  = 4'd6;
	localparam logic [OpWidth-1:0] OP_GE  = 4'd7;
	localparam logic [OpWidth-1:0] OP_EQ  = 4'd8;
	localparam logic [OpWidth-1:0] OP_NE  = 4'd9;
	localparam logic [OpWidth-1:0] OP_NEG = 4'd10;

endpackage

### hw/rtl/rational_number_alu.sv
// Rational number ALU: add, sub, mul, div, negate and compare two fractions,
// with results reduced to lowest terms by a Euclidean GCD. One item at a time.
// Each item runs four bit-serial products. It then runs bit-serial divisions:
// one per Euclid step, then two by the GCD. Comparisons and zero denominators
// skip the divisions, and a zero numerator skips Euclid. A stalled output beat
// holds off the next item.
module rational_number_alu #(
	parameter int OPERAND_WIDTH = rna_pkg::OperandWidthDefault
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            in_valid,
	output logic                            in_stall,
	input  logic [rna_pkg::OpWidth-1:0]     operation,
	input  logic signed [OPERAND_WIDTH-1:0] num_a,
	input  logic [OPERAND_WIDTH-2:0]        den_a,
	input  logic signed [OPERAND_WIDTH-1:0] num_b,
	input  logic [OPERAND_WIDTH-2:0]        den_b,
	output logic                            out_valid,
	input  logic                            out_stall,
	output logic signed [rna_pkg::ResNumWidth-1:0] result_num,
	output logic [rna_pkg::ResDenWidth-1:0] result_den,
	output logic                            compare_true,
	output logic                            status
);
	localparam int W  = OPERAND_WIDTH;
	localparam int PW = 2 * W;      // product width
	localparam int SW = PW + 1;     // sum width
	localparam int ResNumWidth = rna_pkg::ResNumWidth;
	localparam int ResDenWidth = rna_pkg::ResDenWidth;

	localparam logic [3:0] S_IDLE = 4'd0;
	localparam logic [3:0] S_M1   = 4'd1;  // left = |na|*db
	localparam logic [3:0] S_M2   = 4'd2;  // right = |nb|*da
	localparam logic [3:0] S_M3   = 4'd3;  // aux numerator product
	localparam logic [3:0] S_M4   = 4'd4;  // denominator product
	localparam logic [3:0] S_FORM = 4'd5;
	localparam logic [3:0] S_GCD  = 4'd6;
	localparam logic [3:0] S_DN   = 4'd7;
	localparam logic [3:0] S_DD   = 4'd8;
	localparam logic [3:0] S_OUT  = 4'd9;

	logic [3:0]          st_q;
	logic [3:0]          op_q;
	logic                nan_q, nbn_q;
	logic [W-1:0]        ma_q, mb_q;
	logic [W-1:0]        da_q, db_q;
	logic [PW-1:0]       left_q, right_q, aux_q;
	logic [SW-1:0]       nmag_q, dmag_q, gp_q, gq_q, m_q;
	logic                nneg_q;
	logic                mstart_q, dstart_q;
	logic [W-1:0]        ma_in, mb_in;
	logic                mdone, ddone;
	logic [PW-1:0]       prod;
	logic [SW-1:0]       dv_a, dv_b, quot, rem;
	logic                cmp_true;

	logic [W-1:0] abs_a, abs_b;
	assign abs_a = num_a[W-1] ? W'(-num_a) : W'(num_a);
	assign abs_b = num_b[W-1] ? W'(-num_b) : W'(num_b);

	rna_mul #(.W(W)) u_mul (
		.clk(clk), .arst_n(arst_n), .start(mstart_q),
		.a(ma_in), .b(mb_in), .done(mdone), .prod(prod)
	);

	rna_div #(.W(SW)) u_div (
		.clk(clk), .arst_n(arst_n), .start(dstart_q),
		.dividend(dv_a), .divisor(dv_b), .done(ddone), .quot(quot), .rem(rem)
	);

	always_comb begin
		unique case (st_q)
			S_M1:    begin ma_in = ma_q; mb_in = db_q; end
			S_M2:    begin ma_in = mb_q; mb_in = da_q; end
			S_M3:    begin
				ma_in = ma_q;
				mb_in = (op_q == rna_pkg::OP_DIV) ? db_q : mb_q;
			end
			S_M4:    begin
				ma_in = da_q;
				mb_in = (op_q == rna_pkg::OP_DIV) ? mb_q : db_q;
			end
			default: begin ma_in = ma_q; mb_in = db_q; end
		endcase
	end

	always_comb begin
		unique case (st_q)
			S_DN:    begin dv_a = nmag_q; dv_b = gp_q; end
			S_DD:    begin dv_a = dmag_q; dv_b = gp_q; end
			default: begin dv_a = gp_q;   dv_b = gq_q; end
		endcase
	end

	// signed compare of left (sign a) vs right (sign b) magnitudes
	logic lz, rz, ln, rn, lt, eq;
	always_comb begin
		lz = (left_q == '0);
		rz = (right_q == '0);
		ln = nan_q && !lz;
		rn = nbn_q && !rz;
		eq = (ln == rn) && (left_q == right_q);
		if (ln != rn)
			lt = ln;
		else if (ln)
			lt = left_q > right_q;
		else
			lt = left_q < right_q;
		unique case (op_q)
			rna_pkg::OP_LT: cmp_true = lt;
			rna_pkg::OP_GT: cmp_true = !lt && !eq;
			rna_pkg::OP_LE: cmp_true = lt || eq;
			rna_pkg::OP_GE: cmp_true = !lt;
			rna_pkg::OP_EQ: cmp_true = eq;
			rna_pkg::OP_NE: cmp_true = !eq;
			default:        cmp_true = 1'b0;
		endcase
	end

	// signed sum of left and (possibly negated) right
	logic          rneg_eff;
	logic [SW-1:0] sum_mag;
	logic          sum_neg;
	always_comb begin
		rneg_eff = (op_q == rna_pkg::OP_SUB) ? !nbn_q : nbn_q;
		if (ln == rneg_eff || lz || rz) begin
			sum_mag = SW'(left_q) + SW'(right_q);
			sum_neg = lz ? rneg_eff : ln;
		end else if (left_q >= right_q) begin
			sum_mag = SW'(left_q - right_q);
			sum_neg = ln;
		end else begin
			sum_mag = SW'(right_q - left_q);
			sum_neg = rneg_eff;
		end
		if (sum_mag == '0)
			sum_neg = 1'b0;
	end

	logic is_cmp, is_frac;
	assign is_cmp  = (op_q >= rna_pkg::OP_LT) && (op_q <= rna_pkg::OP_NE);
	assign is_frac = (op_q <= rna_pkg::OP_DIV) || (op_q == rna_pkg::OP_NEG);

	assign in_stall = (st_q != S_IDLE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q      <= S_IDLE;
			out_valid <= 1'b0;
			mstart_q  <= 1'b0;
			dstart_q  <= 1'b0;
		end else begin
			mstart_q <= ((st_q == S_IDLE) && in_valid) ||
				(((st_q == S_M1) || (st_q == S_M2) || (st_q == S_M3)) && mdone);
			dstart_q <= ((st_q == S_FORM) && is_frac && (dmag_q != '0)) ||
				(((st_q == S_GCD) || (st_q == S_DN)) && ddone);
			if ((st_q == S_OUT) && (!out_valid || !out_stall))
				out_valid <= 1'b1;
			else if (!out_stall)
				out_valid <= 1'b0;
			unique case (st_q)
				S_IDLE: if (in_valid)
					st_q <= S_M1;
				S_M1: if (mdone)
					st_q <= S_M2;
				S_M2: if (mdone)
					st_q <= S_M3;
				S_M3: if (mdone)
					st_q <= S_M4;
				S_M4: if (mdone)
					st_q <= S_FORM;
				S_FORM: begin
					if (!is_frac || dmag_q == '0)
						st_q <= S_OUT;
					else if (nmag_q == '0)
						st_q <= S_DN;
					else
						st_q <= S_GCD;
				end
				S_GCD: if (ddone) begin
					if (rem == '0)
						st_q <= S_DN;
					else
						st_q <= S_GCD;
				end
				S_DN: if (ddone)
					st_q <= S_DD;
				S_DD: if (ddone)
					st_q <= S_OUT;
				S_OUT: if (!out_valid || !out_stall)
					st_q <= S_IDLE;
				default: st_q <= S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		unique case (st_q)
			S_IDLE: begin
				op_q  <= operation;
				nan_q <= num_a[W-1];
				nbn_q <= num_b[W-1];
				ma_q  <= abs_a;
				mb_q  <= abs_b;
				da_q  <= {1'b0, den_a};
				db_q  <= {1'b0, den_b};
			end
			S_M1: if (mdone) left_q  <= prod;
			S_M2: if (mdone) right_q <= prod;
			S_M3: if (mdone) aux_q   <= prod;
			S_M4: if (mdone) begin
				// operand form for the fraction result
				unique case (op_q)
					rna_pkg::OP_ADD, rna_pkg::OP_SUB: begin
						nmag_q <= sum_mag;
						nneg_q <= sum_neg;
						dmag_q <= SW'(prod);
					end
					rna_pkg::OP_MUL, rna_pkg::OP_DIV: begin
						nmag_q <= SW'(aux_q);
						nneg_q <= (nan_q != nbn_q) && (aux_q != '0);
						dmag_q <= SW'(prod);
					end
					default: begin
						nmag_q <= SW'(ma_q);
						nneg_q <= !nan_q && (ma_q != '0);
						dmag_q <= SW'(da_q);
					end
				endcase
			end
			S_FORM: begin
				gq_q <= dmag_q;
				// zero numerator: the GCD is the denominator itself
				if (nmag_q == '0)
					gp_q <= dmag_q;
				else
					gp_q <= nmag_q;
			end
			S_GCD: if (ddone) begin
				if (rem == '0)
					gp_q <= gq_q;
				else begin
					gp_q <= gq_q;
					gq_q <= rem;
				end
			end
			S_DN: if (ddone) m_q <= quot;
			S_DD: if (ddone) dmag_q <= quot;
			S_OUT: if (!out_valid || !out_stall) begin
				compare_true <= is_cmp ? cmp_true : 1'b0;
				if (is_frac && dmag_q != '0) begin
					result_num <= nneg_q ? ResNumWidth'(-m_q) : ResNumWidth'(m_q);
					result_den <= ResDenWidth'(dmag_q);
					status     <= 1'b0;
				end else begin
					result_num <= '0;
					result_den <= ResDenWidth'(1);
					status     <= is_frac;
				end
			end
			default: ;
		endcase
	end
endmodule

### hw/rtl/rna_mul.sv
// Bit-serial shift-and-add multiplier of two unsigned magnitudes.
module rna_mul #(
	parameter int W = 16
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           start,
	input  logic [W-1:0]   a,
	input  logic [W-1:0]   b,
	output logic           done,
	output logic [2*W-1:0] prod
);
	localparam int CW = $clog2(W + 1);

	logic [2*W-1:0] acc_q;
	logic [2*W-1:0] mcand_q;
	logic [W-1:0]   mplier_q;
	logic [CW-1:0]  cnt_q;
	logic           busy_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			cnt_q  <= CW'(W);
		end else if (busy_q) begin
			cnt_q <= cnt_q - 1'b1;
			if (cnt_q == CW'(1))
				busy_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			acc_q    <= '0;
			mcand_q  <= {{W{1'b0}}, a};
			mplier_q <= b;
		end else if (busy_q) begin
			if (mplier_q[0])
				acc_q <= acc_q + mcand_q;
			mcand_q  <= mcand_q << 1;
			mplier_q <= mplier_q >> 1;
		end
	end

	assign done = !busy_q && !start;
	assign prod = acc_q;
endmodule

### hw/rtl/rna_div.sv
// Restoring divider, one quotient bit per cycle.
module rna_div #(
	parameter int W = 32
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         start,
	input  logic [W-1:0] dividend,
	input  logic [W-1:0] divisor,
	output logic         done,
	output logic [W-1:0] quot,
	output logic [W-1:0] rem
);
	localparam int CW = $clog2(W + 1);

	logic [W-1:0]  q_q;
	logic [W:0]    r_q;
	logic [W-1:0]  d_q;
	logic [CW-1:0] cnt_q;
	logic          busy_q;
	logic [W:0]    trial;
	logic [W:0]    diff;

	assign trial = {r_q[W-1:0], q_q[W-1]};
	assign diff  = trial - {1'b0, d_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			cnt_q  <= CW'(W);
		end else if (busy_q) begin
			cnt_q <= cnt_q - 1'b1;
			if (cnt_q == CW'(1))
				busy_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			q_q <= dividend;
			r_q <= '0;
			d_q <= divisor;
		end else if (busy_q) begin
			if (!diff[W]) begin
				r_q <= diff;
				q_q <= {q_q[W-2:0], 1'b1};
			end else begin
				r_q <= trial;
				q_q <= {q_q[W-2:0], 1'b0};
			end
		end
	end

	assign done = !busy_q && !start;
	assign quot = q_q;
	assign rem  = r_q[W-1:0];
endmodule
